// ----- design/lckt_pkg.sv -----
// ----------------------------------------------------------------------------
// lckt_pkg
// Shared types and constants of the learned code key table: the operation
// codes, the transfer payloads of both channels, and the token that moves
// along the row chain.
// ----------------------------------------------------------------------------
package lckt_pkg;

  localparam int CodeW     = 32;
  localparam int KeyW      = 3;
  localparam int KeyIdxW   = 3;
  localparam int ActionW   = 2;

  localparam logic [CodeW-1:0] CodeZero    = '0;
  localparam logic [CodeW-1:0] CodeAllOnes = '1;

  typedef enum logic [ActionW-1:0] {
    ACT_LEARN  = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SAVE   = 2'd2,
    ACT_LOOKUP = 2'd3
  } action_e;

  typedef struct packed {
    action_e              action;
    logic [CodeW-1:0]     code;
    logic                 overflow;
    logic [KeyW-1:0]      key;
  } in_item_t;

  typedef struct packed {
    logic                 added;
    logic                 found;
    logic [KeyIdxW-1:0]   key_index;
  } out_item_t;

  // One operation in flight along the chain of key rows.
  typedef struct packed {
    logic                 valid;
    action_e              action;
    logic [CodeW-1:0]     code;
    logic [KeyW-1:0]      key;
    logic                 added;
    logic                 found;
    logic [KeyIdxW-1:0]   key_index;
  } lckt_token_t;

endpackage

// ----- design/lckt_learn_buf.sv -----
// ----------------------------------------------------------------------------
// lckt_learn_buf
// Learning buffer: stores new codes in the first empty slot, refuses
// duplicates and invalid codes, refuses a code when no slot is empty, and clears on request.
// ----------------------------------------------------------------------------
module lckt_learn_buf #(
  parameter int CodesPerKey = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     op_en_i,
  input  lckt_pkg::in_item_t       item_i,
  output logic                     added_o,
  output logic [lckt_pkg::CodeW-1:0] entry_o [CodesPerKey]
);
  import lckt_pkg::*;

  localparam int SlotW = (CodesPerKey > 1) ? $clog2(CodesPerKey) : 1;

  logic [CodeW-1:0] entry_q [CodesPerKey];
  logic [SlotW-1:0] slot_sel;
  logic             slot_free;
  logic             done;
  logic             code_ok;

  // Slots are scanned in order; a duplicate ahead of the first empty slot
  // ends the scan without storing.
  always_comb begin
    done      = 1'b0;
    slot_free = 1'b0;
    slot_sel  = '0;
    for (int s = 0; s < CodesPerKey; s++) begin
      if (!done) begin
        if (entry_q[s] == item_i.code) begin
          done = 1'b1;
        end else if (entry_q[s] == CodeZero) begin
          done      = 1'b1;
          slot_free = 1'b1;
          slot_sel  = SlotW'(s);
        end
      end
    end
  end

  assign code_ok = !item_i.overflow && (item_i.code != CodeZero) &&
                   (item_i.code != CodeAllOnes);
  assign added_o = (item_i.action == ACT_LEARN) && code_ok && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CodesPerKey; s++) entry_q[s] <= '0;
    end else if (op_en_i) begin
      if (item_i.action == ACT_CLEAR) begin
        for (int s = 0; s < CodesPerKey; s++) entry_q[s] <= '0;
      end else if (added_o) begin
        entry_q[slot_sel] <= item_i.code;
      end
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- design/lckt_cell.sv -----
// ----------------------------------------------------------------------------
// lckt_cell
// One key row of the table. It compares a passing lookup against its codes,
// takes the learning buffer on a save addressed to it, and hands the token
// on to the next row through a register.
// ----------------------------------------------------------------------------
module lckt_cell #(
  parameter int CodesPerKey = 4,
  parameter int Index       = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lckt_pkg::lckt_token_t      tok_i,
  input  logic [lckt_pkg::CodeW-1:0] lbuf_i [CodesPerKey],
  output lckt_pkg::lckt_token_t      tok_o
);
  import lckt_pkg::*;

  localparam logic [31:0] IndexL = 32'(Index);

  logic [CodeW-1:0] row_q [CodesPerKey];
  lckt_token_t      tok_d;
  lckt_token_t      tok_q;
  logic             row_hit;
  logic             save_here;

  always_comb begin
    row_hit = 1'b0;
    for (int s = 0; s < CodesPerKey; s++) begin
      if (row_q[s] == tok_i.code) row_hit = 1'b1;
    end
  end

  assign save_here = tok_i.valid && (tok_i.action == ACT_SAVE) &&
                     (32'(tok_i.key) == IndexL);

  // The first row that hits wins; later rows leave the result alone.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && (tok_i.action == ACT_LOOKUP) && !tok_i.found && row_hit) begin
      tok_d.found     = 1'b1;
      tok_d.key_index = IndexL[KeyIdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      for (int s = 0; s < CodesPerKey; s++) row_q[s] <= '0;
    end else begin
      tok_q <= tok_d;
      if (save_here) begin
        for (int s = 0; s < CodesPerKey; s++) row_q[s] <= lbuf_i[s];
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- design/learned_code_key_table_unit.sv -----
// ----------------------------------------------------------------------------
// learned_code_key_table_unit
// Learning buffer and key table for received remote codes.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid_i / in_data_i and results leave on
// out_valid_o / out_data_o; each side accepts a transfer when valid is high
// and its stall is low. Every item gives exactly one result.
// Learn and clear act on the learning buffer in the cycle of the transfer.
// Every item then travels as a token down a chain of NumKeys row cells, one
// row per cycle, so save reaches its row and lookup sees the rows in key
// order. The result is registered at the end of the chain.
// The result passes the NumKeys row registers and then the output register
// before out_valid_o rises. Only one item is in flight at a time; the next
// item is taken in the cycle after the result transfer.
// While out_stall_i is high the result holds and in_stall_o stays high.
// Reset clears the buffer and all rows to zero at once; no clearing pass.
// ----------------------------------------------------------------------------
module learned_code_key_table_unit #(
  parameter int NumKeys     = 8,
  parameter int CodesPerKey = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lckt_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lckt_pkg::out_item_t  out_data_o
);
  import lckt_pkg::*;

  logic             busy_q;
  logic             out_valid_q;
  out_item_t        out_q;
  logic             in_xfer;
  logic             out_xfer;
  logic             added;
  logic [CodeW-1:0] lbuf [CodesPerKey];
  lckt_token_t      tok [NumKeys+1];
  logic [NumKeys:0] tok_vld;

  assign in_xfer  = in_valid_i && !busy_q;
  assign out_xfer = out_valid_q && !out_stall_i;

  lckt_learn_buf #(
    .CodesPerKey (CodesPerKey)
  ) u_learn_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_en_i (in_xfer),
    .item_i  (in_data_i),
    .added_o (added),
    .entry_o (lbuf)
  );

  always_comb begin
    tok[0].valid     = in_xfer;
    tok[0].action    = in_data_i.action;
    tok[0].code      = in_data_i.code;
    tok[0].key       = in_data_i.key;
    tok[0].added     = added;
    tok[0].found     = 1'b0;
    tok[0].key_index = '0;
  end

  for (genvar k = 0; k < NumKeys; k++) begin : g_row
    lckt_cell #(
      .CodesPerKey (CodesPerKey),
      .Index       (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[k]),
      .lbuf_i (lbuf),
      .tok_o  (tok[k+1])
    );
  end

  for (genvar k = 0; k <= NumKeys; k++) begin : g_vld
    assign tok_vld[k] = tok[k].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (out_xfer) begin
        busy_q <= 1'b0;
      end
      if (tok[NumKeys].valid) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[NumKeys].valid) begin
      out_q.added     <= tok[NumKeys].added;
      out_q.found     <= tok[NumKeys].found;
      out_q.key_index <= tok[NumKeys].key_index;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // At most one operation is ever in flight along the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one token in the row chain");

  // A token leaves the chain only for an item in progress whose result slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NumKeys].valid |-> (busy_q && !out_valid_q))
    else $error("token left the chain outside an item");

  // A pending result always belongs to an item still counted as busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q)
    else $error("result pending while idle");

  // Delivering the result frees the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |=> !busy_q)
    else $error("still busy after result transfer");

endmodule
